// ----- rtl/pcbs_pkg.sv -----
// Package for the partition-compatible block splitter.
// Holds default sizes, stream field widths and register offsets.
// No dependencies.
package pcbs_pkg;

    localparam int TAXA_DEFAULT        = 16;
    localparam int SYMBOL_BITS_DEFAULT = 8;

    localparam int SYMBOL_W   = 8;
    localparam int POSITION_W = 31;
    localparam int COUNT_W    = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_TAXA_COUNT = 1'b0;

    localparam logic [COUNT_W-1:0] TAXA_COUNT_RESET = 5'd16;

endpackage

// ----- rtl/partition_compatible_block_splitter.sv -----
// Top level of the partition-compatible block splitter.
// Depends on pcbs_pkg for field widths, defaults and register offsets.
// Usage:
//   s_* stream: one symbol per transfer, taxa_count transfers per column.
//     s_tdata = {position, symbol}, s_tlast = final_column. position and
//     final_column are sampled on the last symbol of a column.
//   m_* stream: one closed block (begin, end) per transfer.
//     m_tdata = {block_end, block_begin}, m_tlast = last result of the column.
//   APB: register taxa_count at offset 0x0; write only while the block is idle.
// Timing:
//   Input register, one pass of logic, result register: one symbol per
//   cycle unless a stall holds the input register. A closing column's last
//   symbol passes the input register, then the result register; a column
//   that gives two results holds the result register for two transfers.
//   The symbol table is a 2^SYMBOL_BITS entry memory read when a symbol is
//   taken, with a bypass for the same symbol back to back; its valid bits are
//   flops cleared at the end of every column.
// Reset: no block open, column empty, taxa_count = 16. No clearing pass.
// Stall: the result register holds; further columns keep flowing until a
//   column that closes a block needs the result register.
module partition_compatible_block_splitter #(
    parameter int TAXA        = pcbs_pkg::TAXA_DEFAULT,
    parameter int SYMBOL_BITS = pcbs_pkg::SYMBOL_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // s_tdata: symbol [7:0], position [38:8], zero [39]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pcbs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    // m_tdata: block_begin [30:0], block_end [61:31], zero [63:62]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcbs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcbs_pkg::PADDR_W-1:0]   paddr,
    input  logic [pcbs_pkg::PDATA_W-1:0]   pwdata,
    output logic [pcbs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int POS_W     = pcbs_pkg::POSITION_W;
    localparam int CLS_W     = $clog2(TAXA);
    localparam int CNT_W     = $clog2(TAXA + 1);
    localparam int NW        = (CNT_W > pcbs_pkg::COUNT_W) ? CNT_W : pcbs_pkg::COUNT_W;
    localparam int SYM_DEPTH = 1 << SYMBOL_BITS;
    localparam int ENT_W     = 2 * CLS_W;

    // ---------------- configuration ----------------
    logic [pcbs_pkg::COUNT_W-1:0] taxa_count_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == pcbs_pkg::REG_TAXA_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taxa_count_reg <= pcbs_pkg::TAXA_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            taxa_count_reg <= pwdata[pcbs_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == pcbs_pkg::REG_TAXA_COUNT)
        begin
            prdata = {{(pcbs_pkg::PDATA_W - pcbs_pkg::COUNT_W){1'b0}}, taxa_count_reg};
        end
    end

    // ---------------- input register ----------------
    logic                   s1_valid_reg;
    logic [SYMBOL_BITS-1:0] s1_sym_reg;
    logic [POS_W-1:0]       s1_pos_reg;
    logic                   s1_fin_reg;
    logic                   s1_fire;
    logic                   accept;
    logic [SYMBOL_BITS-1:0] in_sym;

    assign in_sym   = s_tdata[SYMBOL_BITS-1:0];
    assign s_tready = !s1_valid_reg || s1_fire;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sym_reg <= in_sym;
            s1_pos_reg <= s_tdata[pcbs_pkg::SYMBOL_W +: POS_W];
            s1_fin_reg <= s_tlast;
        end
    end

    // ---------------- symbol table ----------------
    // entry: {block class of first taxon, column class}
    logic [ENT_W-1:0]     sym_mem [SYM_DEPTH];
    logic [ENT_W-1:0]     sym_rd_reg;
    logic [SYM_DEPTH-1:0] sym_valid_reg;
    logic [SYM_DEPTH-1:0] sym_valid_next;
    logic                 mem_wr;
    logic [ENT_W-1:0]     mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            sym_mem[s1_sym_reg] <= mem_wdata;
        end
        if (accept)
        begin
            if (mem_wr && (s1_sym_reg == in_sym))
            begin
                sym_rd_reg <= mem_wdata;
            end
            else
            begin
                sym_rd_reg <= sym_mem[in_sym];
            end
        end
    end

    // ---------------- column / block state ----------------
    logic [CLS_W-1:0] block_class_reg  [TAXA];
    logic [CLS_W-1:0] block_class_next [TAXA];
    logic [CLS_W-1:0] column_class_reg [TAXA];
    logic [CLS_W-1:0] column_class_next[TAXA];
    logic [CNT_W-1:0] class_count_reg, class_count_next;
    logic [CLS_W-1:0] taxon_index_reg, taxon_index_next;
    logic             column_fits_reg, column_fits_next;
    logic             block_open_reg, block_open_next;
    logic [POS_W-1:0] begin_pos_reg, begin_pos_next;
    logic [POS_W-1:0] prev_pos_reg, prev_pos_next;

    // result register: up to two results of one column
    logic             o_valid_reg, o_valid_next;
    logic             o_sel_reg, o_sel_next;
    logic             o_two_reg, o_two_next;
    logic [POS_W-1:0] o_b0_reg, o_b0_next;
    logic [POS_W-1:0] o_e0_reg, o_e0_next;
    logic [POS_W-1:0] o_b1_reg, o_b1_next;
    logic [POS_W-1:0] o_e1_reg, o_e1_next;

    logic [CLS_W-1:0] t;
    logic [CLS_W-1:0] c;
    logic [CLS_W-1:0] blk_t;
    logic [CLS_W-1:0] ent_cls;
    logic [CLS_W-1:0] ent_blk;
    logic [CLS_W-1:0] col_cls;
    logic [NW-1:0]    n_eff;
    logic [NW-1:0]    t_plus;
    logic             hit;
    logic             mismatch;
    logic             fits_now;
    logic             last_sym;
    logic             emit0;
    logic             open_new;
    logic             has_res;
    logic             out_free;
    logic [POS_W-1:0] begin_after;

    assign m_tvalid = o_valid_reg;
    assign m_tlast  = !o_two_reg || o_sel_reg;
    assign m_tdata  = o_sel_reg ? {2'b00, o_e1_reg, o_b1_reg} : {2'b00, o_e0_reg, o_b0_reg};
    assign out_free = !o_valid_reg || (m_tready && m_tlast);

    always_comb
    begin
        t = (taxon_index_reg > CLS_W'(TAXA - 1)) ? CLS_W'(TAXA - 1) : taxon_index_reg;
        c = (class_count_reg >= CNT_W'(TAXA)) ? CLS_W'(TAXA - 1)
                                              : class_count_reg[CLS_W-1:0];
        n_eff = NW'(taxa_count_reg);
        if (n_eff == '0)
        begin
            n_eff = NW'(1);
        end
        if (n_eff > NW'(TAXA))
        begin
            n_eff = NW'(TAXA);
        end
        t_plus   = NW'(t) + NW'(1);
        last_sym = !(t_plus < n_eff);

        blk_t    = block_class_reg[t];
        hit      = sym_valid_reg[s1_sym_reg];
        ent_cls  = sym_rd_reg[CLS_W-1:0];
        ent_blk  = sym_rd_reg[ENT_W-1:CLS_W];
        mismatch = hit && block_open_reg && (blk_t != ent_blk);
        col_cls  = hit ? ent_cls : c;
        fits_now = column_fits_reg && !mismatch;

        emit0       = last_sym && block_open_reg && !fits_now;
        open_new    = !block_open_reg || !fits_now;
        begin_after = open_new ? s1_pos_reg : begin_pos_reg;
        has_res     = last_sym && (emit0 || s1_fin_reg);
        s1_fire     = s1_valid_reg && (!has_res || out_free);

        mem_wr    = s1_fire && !hit;
        mem_wdata = {(block_open_reg ? blk_t : CLS_W'(0)), c};

        for (int i = 0; i < TAXA; i++)
        begin
            column_class_next[i] = column_class_reg[i];
        end
        column_class_next[t] = col_cls;
        for (int i = 0; i < TAXA; i++)
        begin
            block_class_next[i] = block_class_reg[i];
        end

        sym_valid_next   = sym_valid_reg;
        class_count_next = class_count_reg;
        taxon_index_next = taxon_index_reg;
        column_fits_next = column_fits_reg;
        block_open_next  = block_open_reg;
        begin_pos_next   = begin_pos_reg;
        prev_pos_next    = prev_pos_reg;

        o_valid_next = o_valid_reg;
        o_sel_next   = o_sel_reg;
        o_two_next   = o_two_reg;
        o_b0_next    = o_b0_reg;
        o_e0_next    = o_e0_reg;
        o_b1_next    = o_b1_reg;
        o_e1_next    = o_e1_reg;

        if (o_valid_reg && m_tready)
        begin
            if (m_tlast)
            begin
                o_valid_next = 1'b0;
                o_sel_next   = 1'b0;
            end
            else
            begin
                o_sel_next = 1'b1;
            end
        end

        if (s1_fire)
        begin
            if (!last_sym)
            begin
                if (!hit)
                begin
                    sym_valid_next[s1_sym_reg] = 1'b1;
                    if (class_count_reg < CNT_W'(TAXA))
                    begin
                        class_count_next = class_count_reg + CNT_W'(1);
                    end
                end
                taxon_index_next = CLS_W'(t_plus);
                column_fits_next = fits_now;
            end
            else
            begin
                if (open_new)
                begin
                    for (int i = 0; i < TAXA; i++)
                    begin
                        block_class_next[i] = column_class_next[i];
                    end
                    begin_pos_next = s1_pos_reg;
                end
                prev_pos_next   = s1_pos_reg;
                block_open_next = !s1_fin_reg;

                sym_valid_next   = '0;
                class_count_next = '0;
                taxon_index_next = '0;
                column_fits_next = 1'b1;

                if (has_res)
                begin
                    o_valid_next = 1'b1;
                    o_sel_next   = 1'b0;
                    o_two_next   = emit0 && s1_fin_reg;
                    o_b0_next    = emit0 ? begin_pos_reg : begin_after;
                    o_e0_next    = emit0 ? prev_pos_reg : s1_pos_reg;
                    o_b1_next    = begin_after;
                    o_e1_next    = s1_pos_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_valid_reg   <= '0;
            class_count_reg <= '0;
            taxon_index_reg <= '0;
            column_fits_reg <= 1'b1;
            block_open_reg  <= 1'b0;
            begin_pos_reg   <= '0;
            prev_pos_reg    <= '0;
            o_valid_reg     <= 1'b0;
            o_sel_reg       <= 1'b0;
        end
        else
        begin
            sym_valid_reg   <= sym_valid_next;
            class_count_reg <= class_count_next;
            taxon_index_reg <= taxon_index_next;
            column_fits_reg <= column_fits_next;
            block_open_reg  <= block_open_next;
            begin_pos_reg   <= begin_pos_next;
            prev_pos_reg    <= prev_pos_next;
            o_valid_reg     <= o_valid_next;
            o_sel_reg       <= o_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_class_reg  <= block_class_next;
        column_class_reg <= column_class_next;
        o_two_reg        <= o_two_next;
        o_b0_reg         <= o_b0_next;
        o_e0_reg         <= o_e0_next;
        o_b1_reg         <= o_b1_next;
        o_e1_reg         <= o_e1_next;
    end

endmodule
